// File: design/fliu_pkg.sv
package fliu_pkg;

    // Request codes carried in tuser of the slave side
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_PUSH  = 2'd0;
    localparam mode_t MODE_FRAME = 2'd1;
    localparam mode_t MODE_FLUSH = 2'd2;

    // How the result stage forms the output sample
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ZERO   = 2'd0;
    localparam kind_t KIND_HOLD   = 2'd1;
    localparam kind_t KIND_INTERP = 2'd2;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_TX_ENABLE  = 1'b0;
    localparam logic REG_PHASE_STEP = 1'b1;

    localparam int SAMPLE_W = 16;

endpackage

// File: design/fifo_linear_interp_upsampler.sv
// Channel   | Direction | Signals                               | Content
// ----------+-----------+---------------------------------------+-----------------------------
// s_axis    | in        | tvalid tready tdata[15:0] tuser[1:0]  | sample_in / mode
// m_axis    | out       | tvalid tready tdata                   | sample_out, accepted,
//           |           |                                       | overrun, underrun, playing,
//           |           |                                       | fill_level
// apb       | in/out    | psel penable pwrite paddr pwdata ...  | 0x0 tx_enable, 0x4 phase_step
//
// One item per cycle sustained while the output takes results; an item passes stage 1, then the result stage.
// Pointers, count and phase update at the input transfer; the sample memory is read
// at the same edge and the single interpolation multiplier sits in the second stage.
// Reset clears pointers, count, phase, playback and the pipeline valids; the sample
// memory is not cleared and needs no clearing pass.
// A stalled output holds the result stage; one more item is still taken in.
module fifo_linear_interp_upsampler #(
    parameter int BUFFER_DEPTH    = 4096,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] sample_out, [16] accepted, [17] overrun, [18] underrun, [19] playing,
    // then fill_level, zero padded to whole bytes
    output logic [((20+$clog2(BUFFER_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(BUFFER_DEPTH);
    localparam int CW     = $clog2(BUFFER_DEPTH + 1);
    localparam int F      = PHASE_FRAC_BITS;
    localparam int PW     = F + 2;
    localparam int STEP_W = F + 1;
    localparam int SW     = ((AW > 3) ? AW : 3) + 1;
    localparam int XW     = (CW > 3) ? CW : 3;
    localparam int OUT_W  = 20 + CW;
    localparam int TD_W   = ((OUT_W + 7) / 8) * 8;

    // configuration
    logic              tx_enable_reg;
    logic [STEP_W-1:0] phase_step_reg;

    // buffer state
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic          play_reg, play_next;

    logic [15:0] mem [BUFFER_DEPTH];
    logic        mem_we;

    // stage 1: read data and item status
    logic                 s1_valid_reg;
    fliu_pkg::kind_t      s1_kind_reg;
    logic [F-1:0]         s1_frac_reg;
    logic                 s1_acc_reg;
    logic                 s1_ovr_reg;
    logic                 s1_und_reg;
    logic                 s1_play_reg;
    logic [CW-1:0]        s1_fill_reg;
    logic [15:0]          rd0_reg;
    logic [15:0]          rd1_reg;

    // result stage
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic            in_xfer;
    logic            advance;
    fliu_pkg::mode_t mode;
    fliu_pkg::kind_t kind;
    logic            acc_flag;
    logic            ovr_flag;
    logic            und_flag;
    logic [1:0]      idx0;
    logic [XW-1:0]   cnt_x;
    logic [SW-1:0]   a0_sum, a1_sum, rp_sum, wp_sum;
    logic [AW-1:0]   a0, a1, rp_pop, wp_inc;
    logic [PW:0]     phase_sum;
    logic [PW-1:0]   phase_sat;
    logic [1:0]      ip;
    logic [1:0]      pops;
    logic [15:0]     interp_out;

    assign pready        = 1'b1;
    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign mode          = s_axis_tuser;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TD_W'(m_data_reg);

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_enable_reg  <= 1'b0;
            phase_step_reg <= STEP_W'(1) << (F - 2);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                fliu_pkg::REG_TX_ENABLE:  tx_enable_reg  <= pwdata[0];
                fliu_pkg::REG_PHASE_STEP: phase_step_reg <= pwdata[STEP_W-1:0];
                default:                  tx_enable_reg  <= tx_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fliu_pkg::REG_TX_ENABLE:  prdata = 32'(tx_enable_reg);
            fliu_pkg::REG_PHASE_STEP: prdata = 32'(phase_step_reg);
            default:                  prdata = '0;
        endcase
    end

    // Read addresses and pointer arithmetic
    assign idx0   = phase_reg[PW-1:F];
    assign cnt_x  = XW'(count_reg);
    assign a0_sum = SW'(rp_reg) + SW'(idx0);
    assign a1_sum = a0_sum + SW'(1);
    assign a0     = AW'((a0_sum >= SW'(BUFFER_DEPTH)) ? a0_sum - SW'(BUFFER_DEPTH) : a0_sum);
    assign a1     = AW'((a1_sum >= SW'(BUFFER_DEPTH)) ? a1_sum - SW'(BUFFER_DEPTH) : a1_sum);
    assign wp_sum = SW'(wp_reg) + SW'(1);
    assign wp_inc = AW'((wp_sum >= SW'(BUFFER_DEPTH)) ? wp_sum - SW'(BUFFER_DEPTH) : wp_sum);

    // Advance the phase with saturation, then pop whole samples consumed
    assign phase_sum = {1'b0, phase_reg} + (PW+1)'(phase_step_reg);
    assign phase_sat = phase_sum[PW] ? {PW{1'b1}} : phase_sum[PW-1:0];
    assign ip        = phase_sat[PW-1:F];
    assign pops      = (XW'(ip) > cnt_x) ? count_reg[1:0] : ip;
    assign rp_sum    = SW'(rp_reg) + SW'(pops);
    assign rp_pop    = AW'((rp_sum >= SW'(BUFFER_DEPTH)) ? rp_sum - SW'(BUFFER_DEPTH) : rp_sum);

    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        play_next  = play_reg;
        kind       = fliu_pkg::KIND_ZERO;
        acc_flag   = 1'b0;
        ovr_flag   = 1'b0;
        und_flag   = 1'b0;
        mem_we     = 1'b0;
        if (in_xfer)
        begin
            unique case (mode)
                fliu_pkg::MODE_PUSH:
                begin
                    if (tx_enable_reg)
                    begin
                        if (count_reg >= CW'(BUFFER_DEPTH))
                        begin
                            ovr_flag = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            wp_next    = wp_inc;
                            count_next = count_reg + CW'(1);
                            acc_flag   = 1'b1;
                        end
                        if (!play_reg)
                        begin
                            play_next  = 1'b1;
                            phase_next = '0;
                        end
                    end
                end
                fliu_pkg::MODE_FRAME:
                begin
                    if (play_reg && tx_enable_reg)
                    begin
                        if (cnt_x > XW'(idx0) + XW'(1))
                        begin
                            kind = fliu_pkg::KIND_INTERP;
                        end
                        else if (cnt_x > XW'(idx0))
                        begin
                            kind = fliu_pkg::KIND_HOLD;
                        end
                        else
                        begin
                            und_flag  = 1'b1;
                            play_next = 1'b0;
                        end
                        phase_next = {ip - pops, phase_sat[F-1:0]};
                        rp_next    = rp_pop;
                        count_next = count_reg - CW'(pops);
                    end
                end
                fliu_pkg::MODE_FLUSH:
                begin
                    rp_next    = '0;
                    wp_next    = '0;
                    count_next = '0;
                    phase_next = '0;
                    play_next  = 1'b0;
                end
                default:
                begin
                    play_next = play_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg       <= '0;
            wp_reg       <= '0;
            count_reg    <= '0;
            phase_reg    <= '0;
            play_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            play_reg  <= play_next;
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                m_valid_reg <= s1_valid_reg;
        end
    end

    // Sample memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= s_axis_tdata;
        if (in_xfer)
        begin
            rd0_reg <= mem[a0];
            rd1_reg <= mem[a1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_kind_reg <= kind;
            s1_frac_reg <= phase_reg[F-1:0];
            s1_acc_reg  <= acc_flag;
            s1_ovr_reg  <= ovr_flag;
            s1_und_reg  <= und_flag;
            s1_play_reg <= play_next;
            s1_fill_reg <= count_next;
        end
        if (advance && s1_valid_reg)
            m_data_reg <= {s1_fill_reg, s1_play_reg, s1_und_reg, s1_ovr_reg, s1_acc_reg,
                           interp_out};
    end

    fliu_interp #(
        .FRAC_BITS (F)
    ) u_interp (
        .kind   (s1_kind_reg),
        .frac   (s1_frac_reg),
        .s0     (rd0_reg),
        .s1     (rd1_reg),
        .result (interp_out)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUFFER_DEPTH))
        else $error("sample count beyond buffer depth");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are held");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> m_valid_reg)
        else $error("stage 1 item lost on its way to the output");

    a_push_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg[16] && m_data_reg[17]))
        else $error("push both stored and dropped");

    a_underrun_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[18]) |-> !m_data_reg[19])
        else $error("underrun reported while still playing");
`endif

endmodule

// File: design/fliu_interp.sv
module fliu_interp #(
    parameter int FRAC_BITS = 16
) (
    input  fliu_pkg::kind_t                     kind,
    input  logic [FRAC_BITS-1:0]                frac,
    input  logic [fliu_pkg::SAMPLE_W-1:0]       s0,
    input  logic [fliu_pkg::SAMPLE_W-1:0]       s1,
    output logic [fliu_pkg::SAMPLE_W-1:0]       result
);

    localparam int ACC_W = FRAC_BITS + 18;

    logic [fliu_pkg::SAMPLE_W-1:0] s1_eff;
    logic signed [16:0]            diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [ACC_W-1:0]       prod;
    logic signed [ACC_W-1:0]       base;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       biased;

    // s0*(1-f) + s1*f rewritten as s0 + (s1-s0)*f: one multiplier
    assign s1_eff = (kind == fliu_pkg::KIND_HOLD) ? s0 : s1;
    assign diff   = $signed({s1_eff[15], s1_eff}) - $signed({s0[15], s0});
    assign frac_s = $signed({1'b0, frac});
    assign prod   = diff * frac_s;
    assign base   = $signed({{2{s0[15]}}, s0, {FRAC_BITS{1'b0}}});
    assign acc    = base + prod;

    // Truncate toward zero: bias negative sums before dropping fraction bits
    assign biased = acc[ACC_W-1]
                  ? acc + $signed({{18{1'b0}}, {FRAC_BITS{1'b1}}})
                  : acc;

    always_comb
    begin
        case (kind) inside
            fliu_pkg::KIND_HOLD, fliu_pkg::KIND_INTERP:
                result = biased[FRAC_BITS+15:FRAC_BITS];
            default:
                result = '0;
        endcase
    end

endmodule

// File: tb/tb_fifo_linear_interp_upsampler.sv
module tb_fifo_linear_interp_upsampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int PHASE_ONE   = 1 << FRAC_BITS;
    localparam int PHASE_TOP   = (1 << (FRAC_BITS + 2)) - 1;
    localparam int OUT_W       = 40;
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam logic [2:0] REG_TX_ENABLE  = {fliu_pkg::REG_TX_ENABLE, 2'b00};
    localparam logic [2:0] REG_PHASE_STEP = {fliu_pkg::REG_PHASE_STEP, 2'b00};

    // Code three is left unused by the block
    localparam fliu_pkg::mode_t MODE_UNUSED = 2'd3;

    // Same bit order as m_axis_tdata[32:0]
    typedef struct packed {
        logic [12:0] fill;
        logic        play;
        logic        und;
        logic        ovr;
        logic        acc;
        logic [15:0] sample;
    } frame_out_t;

    localparam frame_out_t QUIET = '0;

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [2:0]      addr;
        fliu_pkg::mode_t mode;
        logic [31:0]     value;
        logic            pin;
        frame_out_t      want;
    } row_t;

    localparam int ROWS = 30;

    localparam row_t PLAN [0:ROWS-1] = '{
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_7FFF, 1'b1, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b1, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  MODE_UNUSED,          32'h0000_FFFF, 1'b1, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FLUSH, 32'h0000_8000, 1'b1, QUIET},
        '{ROW_REG,  REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_0001, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_7FFF, 1'b1,
          '{13'd1, 1'b1, 1'b0, 1'b0, 1'b1, 16'h0000}},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_8000, 1'b1,
          '{13'd2, 1'b1, 1'b0, 1'b0, 1'b1, 16'h0000}},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b1,
          '{13'd2, 1'b1, 1'b0, 1'b0, 1'b0, 16'h7FFF}},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        // one sample left: held
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b1,
          '{13'd1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000}},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        // buffer empty while playing: underrun, playback stops
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b1,
          '{13'd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000}},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b1, QUIET},
        '{ROW_REG,  REG_PHASE_STEP, fliu_pkg::MODE_PUSH,  32'h0001_0000, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_0001, 1'b1,
          '{13'd1, 1'b1, 1'b0, 1'b0, 1'b1, 16'h0000}},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_FFFF, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        '{ROW_REG,  REG_PHASE_STEP, fliu_pkg::MODE_PUSH,  32'h0001_FFFF, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_5555, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_AAAA, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        // flush while playing
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FLUSH, 32'h0000_0000, 1'b1, QUIET},
        // zero step: phase stays put
        '{ROW_REG,  REG_PHASE_STEP, fliu_pkg::MODE_PUSH,  32'h0000_0000, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_PUSH,  32'h0000_1234, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET},
        '{ROW_ITEM, REG_TX_ENABLE,  fliu_pkg::MODE_FRAME, 32'h0000_0000, 1'b0, QUIET}
    };

    localparam int STEP_PLAN [0:9] = '{16384, 1, 65536, 131071, 0,
                                       32768, 65535, 3, 100000, 16384};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;

    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b1;
    logic [OUT_W-1:0]  m_axis_tdata;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Pinned expectation travels beside the transfer
    logic              pin_on = 1'b0;
    frame_out_t        pin_res = '0;

    // Converter state as the testbench sees it
    logic [15:0]       ring [0:DEPTH-1];
    int                rd_ptr = 0;
    int                wr_ptr = 0;
    int                level = 0;
    int                phase = 0;
    bit                playing = 1'b0;
    bit                tx_on = 1'b0;
    int                step = 16384;

    frame_out_t        predicted_outputs [$];
    int                err_count = 0;
    int                cycles = 0;
    int                gap_pct = 0;
    int                stall_pct = 0;
    bit                calm = 1'b0;

    fifo_linear_interp_upsampler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        err_count++;
        $display("mismatch %0d at cycle %0d: %s", err_count, cycles, msg);
    endtask

    // Work out the result of one item and advance the converter state
    function automatic frame_out_t convert_item(input fliu_pkg::mode_t mode,
                                                input logic [15:0] din);
        frame_out_t r;
        int         idx0;
        int         frac;
        longint     s0;
        longint     s1;
        longint     mix;
        r = '0;
        case (mode)
            fliu_pkg::MODE_PUSH:
            begin
                if (tx_on)
                begin
                    if (level >= DEPTH)
                        r.ovr = 1'b1;
                    else
                    begin
                        ring[wr_ptr] = din;
                        wr_ptr = (wr_ptr + 1) % DEPTH;
                        level++;
                        r.acc = 1'b1;
                    end
                    if (!playing)
                    begin
                        playing = 1'b1;
                        phase = 0;
                    end
                end
            end
            fliu_pkg::MODE_FRAME:
            begin
                if (playing && tx_on)
                begin
                    idx0 = phase >> FRAC_BITS;
                    frac = phase & (PHASE_ONE - 1);
                    if (level > idx0 + 1)
                    begin
                        s0  = longint'($signed(ring[(rd_ptr + idx0) % DEPTH]));
                        s1  = longint'($signed(ring[(rd_ptr + idx0 + 1) % DEPTH]));
                        mix = s0 * longint'(PHASE_ONE - frac) + s1 * longint'(frac);
                        // truncate toward zero
                        if (mix < 0)
                            r.sample = 16'(-((-mix) >> FRAC_BITS));
                        else
                            r.sample = 16'(mix >> FRAC_BITS);
                    end
                    else if (level > idx0)
                        r.sample = ring[(rd_ptr + idx0) % DEPTH];
                    else
                    begin
                        r.und = 1'b1;
                        playing = 1'b0;
                    end
                    phase += step;
                    if (phase > PHASE_TOP)
                        phase = PHASE_TOP;
                    while (phase >= PHASE_ONE && level > 0)
                    begin
                        rd_ptr = (rd_ptr + 1) % DEPTH;
                        level--;
                        phase -= PHASE_ONE;
                    end
                end
            end
            fliu_pkg::MODE_FLUSH:
            begin
                playing = 1'b0;
                rd_ptr = 0;
                wr_ptr = 0;
                level = 0;
                phase = 0;
            end
            default:
            begin
            end
        endcase
        r.play = playing;
        r.fill = 13'(level);
        return r;
    endfunction

    task automatic check_result(input frame_out_t got, input frame_out_t want,
                                input logic [OUT_W-34:0] pad);
        if (got.sample !== want.sample)
            flag_error($sformatf("sample_out got %0d want %0d",
                                 $signed(got.sample), $signed(want.sample)));
        if (got.acc !== want.acc)
            flag_error($sformatf("accepted got %b want %b", got.acc, want.acc));
        if (got.ovr !== want.ovr)
            flag_error($sformatf("overrun got %b want %b", got.ovr, want.ovr));
        if (got.und !== want.und)
            flag_error($sformatf("underrun got %b want %b", got.und, want.und));
        if (got.play !== want.play)
            flag_error($sformatf("playing got %b want %b", got.play, want.play));
        if (got.fill !== want.fill)
            flag_error($sformatf("fill_level got %0d want %0d", got.fill, want.fill));
        if (pad !== '0)
            flag_error($sformatf("padding bits got %h", pad));
    endtask

    // Score results first, then predict the item taken at the same edge
    always @(posedge clk)
    begin
        frame_out_t calc;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_outputs.size() == 0)
                    flag_error($sformatf("result with nothing pending: %h", m_axis_tdata));
                else
                    check_result(frame_out_t'(m_axis_tdata[32:0]),
                                 predicted_outputs.pop_front(), m_axis_tdata[OUT_W-1:33]);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                calc = convert_item(fliu_pkg::mode_t'(s_axis_tuser), s_axis_tdata);
                predicted_outputs.push_back(pin_on ? pin_res : calc);
            end
        end
    end

    // Output side back-pressure in random bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input fliu_pkg::mode_t mode, input logic [15:0] din,
                             input logic pin, input frame_out_t want);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= din;
        pin_on        <= pin;
        pin_res       <= want;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drop valid and hold until every pending result has been taken
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (predicted_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_TX_ENABLE)
            tx_on = value[0];
        else
            step = int'(value[16:0]);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic fliu_pkg::mode_t pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return fliu_pkg::MODE_PUSH;
        else if (r < 92)
            return fliu_pkg::MODE_FRAME;
        else if (r < 97)
            return fliu_pkg::MODE_FLUSH;
        return MODE_UNUSED;
    endfunction

    initial
    begin
        bit tx_bit;
        for (int i = 0; i < DEPTH; i++)
            ring[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_REG)
            begin
                settle();
                write_reg(PLAN[i].addr, PLAN[i].value);
            end
            else
                send_item(PLAN[i].mode, PLAN[i].value[15:0], PLAN[i].pin, PLAN[i].want);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            settle();
            tx_bit = (ph != 6) && ($urandom_range(0, 4) != 0);
            write_reg(REG_TX_ENABLE, {31'd0, tx_bit});
            write_reg(REG_PHASE_STEP, 32'(STEP_PLAN[ph]));
            gap_pct   = 15 * $urandom_range(0, 2);
            stall_pct = 15 * $urandom_range(0, 2);
            repeat (50) send_item(pick_mode(), rand_sample(), 1'b0, QUIET);
        end

        // Closing stretch at full rate
        calm = 1'b1;
        settle();
        while (!m_axis_tready) @(posedge clk);
        write_reg(REG_PHASE_STEP, 32'd16384);
        repeat (40) send_item(pick_mode(), rand_sample(), 1'b0, QUIET);

        settle();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
